### src/hfq_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helpers for the heightfield height query block.
// No dependencies; imported by every module of the block.
package hfq_pkg;

    localparam int DEF_GRID_SIZE = 128;
    localparam int DEF_FRAC_BITS = 8;

    localparam int CELL_W     = 7;
    localparam int BYTE_W     = 8;
    localparam int POS_W      = 16;
    localparam int HEIGHT_W   = 5;
    localparam int OUT_W      = 13;
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 16;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic load;
        logic step;
    } t_mac_ctl;

    // truncated divide by ten for 0..255: (b * 205) >> 11
    function automatic logic [HEIGHT_W-1:0] div10(input logic [BYTE_W-1:0] b);
        logic [18:0] prod;
        prod = 19'(b) * 19'd205;
        return prod[11 +: HEIGHT_W];
    endfunction

endpackage

### src/heightfield_height_query.sv
`timescale 1ns / 1ps
// Top level of the heightfield height query block: request decode, sequencer
// and output register. Depends on hfq_pkg, hfq_cell_mem and hfq_mac.
//
// Usage:
//   Slave stream carries requests. tuser is the command (write or query).
//   A write stores map_byte / 10 into one grid cell and gives no response;
//   it leaves the sequencer idle, so writes stream back to back.
//   A query reads three cells through the single memory read port, then runs
//   two multiply-accumulate steps on the shared MAC unit. Its response is
//   registered on the master stream after states RA, RB, RC, M1, M2 and
//   DONE, and the slave side is ready again in the cycle the response
//   appears; no new request is taken in between, since the three serial
//   memory reads, two MAC steps and the output load run in turn. A query
//   outside the grid skips them, goes to DONE and responds with hit = 0 and height 0.
//   Master stream: tuser = hit, tdata = interpolated height (Q.FRAC_BITS).
//   After reset the memory is swept to zero, one cell per cycle, through all
//   2^(2*clog2(GRID_SIZE)) cells (16384 at the default size); tready
//   stays low meanwhile.
//   If the receiver stalls, the response holds in the output register and
//   requests are still taken; the next query then finishes and waits with
//   tready low until the held response is taken.
module heightfield_height_query
    import hfq_pkg::*;
#(
    parameter int GRID_SIZE = DEF_GRID_SIZE,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // cell_x[6:0], cell_z[13:7], map_byte[21:14], pos_x[37:22], pos_z[53:38], zero pad
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,
    // cmd[0]
    input  logic                 i_s_axis_tuser,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // ground_height[12:0], zero pad
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,
    // hit[0]
    output logic                 o_m_axis_tuser
);

    localparam int CW    = $clog2(GRID_SIZE);
    localparam int AW    = 2 * CW;
    localparam int ACC_W = HEIGHT_W + FRAC_BITS + 2;
    localparam int ONE   = 1 << FRAC_BITS;
    localparam int LIMIT = (GRID_SIZE - 1) << FRAC_BITS;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_RA   = 7'b0000010,
        S_RB   = 7'b0000100,
        S_RC   = 7'b0001000,
        S_M1   = 7'b0010000,
        S_M2   = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic [CELL_W-1:0] cell_x, cell_z;
    logic [BYTE_W-1:0] map_byte;
    logic [POS_W-1:0]  pos_x, pos_z;
    logic              s_acc;
    logic              mem_busy;
    logic              wr_ok;
    logic [8:0]        cx9, cz9;
    logic              in_range;
    logic [31:0]       px32, pz32, ix32, iz32;
    logic [FRAC_BITS-1:0] fx, fz;
    logic [FRAC_BITS:0]   fsum;

    logic [CW-1:0]        r_ix, r_iz, r_ix1, r_iz1;
    logic [FRAC_BITS-1:0] r_fx, r_fz;
    logic                 r_upper, r_hit;
    logic [HEIGHT_W-1:0]  r_base, r_h10, r_h01;
    logic [AW-1:0]        raddr;
    logic [HEIGHT_W-1:0]  rdata;

    t_mac_ctl             mac_ctl;
    logic [HEIGHT_W-1:0]  mac_base, mac_h;
    logic [FRAC_BITS:0]   mac_fac;
    logic signed [ACC_W-1:0] acc;
    logic [ACC_W-1:0]     acc_pos;
    logic [31:0]          acc32;

    logic               r_out_valid;
    logic               r_out_hit;
    logic [OUT_W-1:0]   r_out_h;
    logic               out_load;

    assign cell_x   = i_s_axis_tdata[6:0];
    assign cell_z   = i_s_axis_tdata[13:7];
    assign map_byte = i_s_axis_tdata[21:14];
    assign pos_x    = i_s_axis_tdata[37:22];
    assign pos_z    = i_s_axis_tdata[53:38];

    assign o_s_axis_tready = (r_state == S_IDLE) && !mem_busy;
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        cx9   = 9'(cell_x);
        cz9   = 9'(cell_z);
        wr_ok = (cx9 < 9'(GRID_SIZE)) && (cz9 < 9'(GRID_SIZE));
        px32  = 32'($signed(pos_x));
        pz32  = 32'($signed(pos_z));
        in_range = !pos_x[POS_W-1] && !pos_z[POS_W-1]
                   && (px32 < 32'(LIMIT)) && (pz32 < 32'(LIMIT));
        ix32  = px32 >> FRAC_BITS;
        iz32  = pz32 >> FRAC_BITS;
        fx    = pos_x[FRAC_BITS-1:0];
        fz    = pos_z[FRAC_BITS-1:0];
        fsum  = {1'b0, fx} + {1'b0, fz};
    end

    hfq_cell_mem #(
        .GRID_SIZE (GRID_SIZE)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (s_acc && (i_s_axis_tuser == CMD_WRITE) && wr_ok),
        .i_waddr ({cz9[CW-1:0], cx9[CW-1:0]}),
        .i_wdata (div10(map_byte)),
        .i_raddr (raddr),
        .o_rdata (rdata),
        .o_busy  (mem_busy)
    );

    always_comb begin
        case (r_state)
            S_RB:    raddr = {r_iz, r_ix1};
            S_RC:    raddr = {r_iz1, r_ix};
            default: raddr = r_upper ? {r_iz1, r_ix1} : {r_iz, r_ix};
        endcase
    end

    always_comb begin
        mac_ctl.load = (r_state == S_RB);
        mac_ctl.step = (r_state == S_M1) || (r_state == S_M2);
        mac_base     = (r_state == S_RB) ? rdata : r_base;
        if (r_state == S_M1) begin
            mac_h   = r_upper ? rdata : r_h10;
            mac_fac = r_upper ? (FRAC_BITS+1)'(ONE) - {1'b0, r_fx} : {1'b0, r_fx};
        end else begin
            mac_h   = r_upper ? r_h10 : r_h01;
            mac_fac = r_upper ? (FRAC_BITS+1)'(ONE) - {1'b0, r_fz} : {1'b0, r_fz};
        end
    end

    hfq_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .i_clk  (i_clk),
        .i_ctl  (mac_ctl),
        .i_base (mac_base),
        .i_h    (mac_h),
        .i_fac  (mac_fac),
        .o_acc  (acc)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_acc && (i_s_axis_tuser == CMD_QUERY)) begin
                    n_state = in_range ? S_RA : S_DONE;
                end
            end
            S_RA:   n_state = S_RB;
            S_RB:   n_state = S_RC;
            S_RC:   n_state = S_M1;
            S_M1:   n_state = S_M2;
            S_M2:   n_state = S_DONE;
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign out_load = (r_state == S_DONE) && (!r_out_valid || i_m_axis_tready);

    always_comb begin
        acc_pos = acc[ACC_W-1] ? '0 : ACC_W'(acc);
        acc32   = 32'(acc_pos);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc && (i_s_axis_tuser == CMD_QUERY)) begin
            r_ix    <= ix32[CW-1:0];
            r_iz    <= iz32[CW-1:0];
            r_ix1   <= ix32[CW-1:0] + 1'b1;
            r_iz1   <= iz32[CW-1:0] + 1'b1;
            r_fx    <= fx;
            r_fz    <= fz;
            r_upper <= (fsum >= (FRAC_BITS+1)'(ONE));
            r_hit   <= in_range;
        end
        if (r_state == S_RB) begin
            r_base <= rdata;
        end
        if (r_state == S_RC) begin
            r_h10 <= rdata;
        end
        if (r_state == S_M1) begin
            r_h01 <= rdata;
        end
        if (out_load) begin
            r_out_hit <= r_hit;
            r_out_h   <= r_hit ? acc32[OUT_W-1:0] : '0;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = M_TDATA_W'(r_out_h);
    assign o_m_axis_tuser  = r_out_hit;

endmodule

### src/hfq_cell_mem.sv
`timescale 1ns / 1ps
// Cell height memory with one write and one registered read port.
// Sweeps every entry to zero after reset. Depends on hfq_pkg.
module hfq_cell_mem
    import hfq_pkg::*;
#(
    parameter int GRID_SIZE = DEF_GRID_SIZE
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_we,
    input  logic [2*$clog2(GRID_SIZE)-1:0] i_waddr,
    input  logic [HEIGHT_W-1:0]        i_wdata,
    input  logic [2*$clog2(GRID_SIZE)-1:0] i_raddr,
    output logic [HEIGHT_W-1:0]        o_rdata,
    output logic                       o_busy
);

    localparam int CW    = $clog2(GRID_SIZE);
    localparam int AW    = 2 * CW;
    localparam int DEPTH = 1 << AW;

    logic [HEIGHT_W-1:0] r_mem [DEPTH];
    logic [AW-1:0]       r_clr_addr;
    logic                r_clr_busy;
    logic [HEIGHT_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_clr_busy;

endmodule

### src/hfq_mac.sv
`timescale 1ns / 1ps
// Shared multiply-accumulate unit: loads acc with base << FRAC_BITS, or does acc += (h - base) * factor.
// Depends on hfq_pkg.
module hfq_mac
    import hfq_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                               i_clk,
    input  t_mac_ctl                           i_ctl,
    input  logic [HEIGHT_W-1:0]                i_base,
    input  logic [HEIGHT_W-1:0]                i_h,
    input  logic [FRAC_BITS:0]                 i_fac,
    output logic signed [HEIGHT_W+FRAC_BITS+1:0] o_acc
);

    localparam int ACC_W  = HEIGHT_W + FRAC_BITS + 2;
    localparam int DIFF_W = HEIGHT_W + 1;
    localparam int PROD_W = DIFF_W + FRAC_BITS + 2;

    logic signed [DIFF_W-1:0]  diff;
    logic signed [PROD_W-1:0]  prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [ACC_W-1:0]   n_acc;

    always_comb begin
        diff = $signed({1'b0, i_h}) - $signed({1'b0, i_base});
        prod = PROD_W'(diff) * $signed(PROD_W'({1'b0, i_fac}));
        n_acc = r_acc;
        if (i_ctl.load) begin
            n_acc = $signed(ACC_W'({i_base, {FRAC_BITS{1'b0}}}));
        end else if (i_ctl.step) begin
            n_acc = r_acc + ACC_W'(prod);
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_acc = r_acc;

endmodule

### tb/sv/heightfield_height_query_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for heightfield_height_query: writes cell heights, queries
// terrain points and checks each response against an in-bench height predictor.
// Depends on hfq_pkg and the heightfield_height_query RTL.
module heightfield_height_query_tb;
    import hfq_pkg::*;

    localparam int GRID           = DEF_GRID_SIZE;
    localparam int FRAC           = DEF_FRAC_BITS;
    localparam int ONE            = 1 << FRAC;
    localparam int EDGE_LIMIT     = (GRID - 1) * ONE;
    localparam int WATCHDOG_LIMIT = 100000;
    localparam int LONG_HOLD      = 300;
    localparam int PHASE_ITEMS    = 250;

    typedef struct {
        logic                    cmd;
        logic [CELL_W-1:0]       cell_x;
        logic [CELL_W-1:0]       cell_z;
        logic [BYTE_W-1:0]       map_byte;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_z;
    } t_request;

    typedef struct packed {
        logic             hit;
        logic [OUT_W-1:0] height;
    } t_height_result;

    class terrain_tracker;
        logic [HEIGHT_W-1:0] cell_h [GRID*GRID];
        t_height_result      expected_heights [$];
        int errors;
        int n_writes;
        int n_queries;
        int n_hits;
        int n_upper;
        int n_checked;

        function new();
            foreach (cell_h[i]) cell_h[i] = '0;
        endfunction

        function t_height_result predict_height(int px, int pz);
            int ix, iz, fx, fz, h, ha, hb, hc;
            t_height_result res;
            res = '0;
            if (px < 0 || pz < 0 || px >= EDGE_LIMIT || pz >= EDGE_LIMIT)
                return res;
            ix = px >>> FRAC;
            iz = pz >>> FRAC;
            fx = px & (ONE - 1);
            fz = pz & (ONE - 1);
            hb = cell_h[iz * GRID + ix + 1];
            hc = cell_h[(iz + 1) * GRID + ix];
            if (fx + fz < ONE) begin
                ha = cell_h[iz * GRID + ix];
                h  = ha * ONE + (hb - ha) * fx + (hc - ha) * fz;
            end else begin
                ha = cell_h[(iz + 1) * GRID + ix + 1];
                h  = ha * ONE + (hc - ha) * (ONE - fx) + (hb - ha) * (ONE - fz);
                n_upper++;
            end
            if (h < 0)
                h = 0;
            n_hits++;
            res.hit    = 1'b1;
            res.height = OUT_W'(h);
            return res;
        endfunction

        task note_request(t_request r);
            if (r.cmd == CMD_WRITE) begin
                n_writes++;
                if (r.cell_x < GRID && r.cell_z < GRID)
                    cell_h[int'(r.cell_z) * GRID + int'(r.cell_x)] = HEIGHT_W'(r.map_byte / 10);
            end else begin
                n_queries++;
                expected_heights.push_back(predict_height(int'(r.pos_x), int'(r.pos_z)));
            end
        endtask

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_response(logic hit, logic [OUT_W-1:0] height);
            t_height_result want;
            if (expected_heights.size() == 0) begin
                report($sformatf("unexpected response hit=%0d height=%0d", hit, height));
                return;
            end
            want = expected_heights.pop_front();
            n_checked++;
            if (hit !== want.hit)
                report($sformatf("response %0d hit=%0d, want %0d", n_checked, hit, want.hit));
            if (height !== want.height)
                report($sformatf("response %0d height=%0d, want %0d",
                                 n_checked, height, want.height));
        endtask
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    // cell_x[6:0], cell_z[13:7], map_byte[21:14], pos_x[37:22], pos_z[53:38], zero pad
    logic [S_TDATA_W-1:0] i_s_axis_tdata = '0;
    // cmd[0]
    logic                 i_s_axis_tuser = 1'b0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    // ground_height[12:0], zero pad
    logic [M_TDATA_W-1:0] o_m_axis_tdata;
    // hit[0]
    logic                 o_m_axis_tuser;

    terrain_tracker terrain;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    bit hold_req = 1'b0;
    int hold_left = 0;
    int stall_cycles = 0;

    heightfield_height_query dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #2 i_clk = ~i_clk;

    // receiver: random backpressure, plus one long hold-off per phase
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            terrain.check_response(o_m_axis_tuser, o_m_axis_tdata[OUT_W-1:0]);
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no request or response moved for %0d cycles", stall_cycles);
            $display("simulation failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_request(t_request r);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= r.cmd;
        i_s_axis_tdata  <= {2'b00, r.pos_z, r.pos_x, r.map_byte, r.cell_z, r.cell_x};
        do @(posedge i_clk); while (!o_s_axis_tready);
        terrain.note_request(r);
        @(negedge i_clk);
    endtask

    task automatic send_write(int x, int z, int b);
        t_request r;
        r.cmd      = CMD_WRITE;
        r.cell_x   = CELL_W'(x);
        r.cell_z   = CELL_W'(z);
        r.map_byte = BYTE_W'(b);
        r.pos_x    = POS_W'($urandom);
        r.pos_z    = POS_W'($urandom);
        send_request(r);
    endtask

    task automatic send_query(int px, int pz);
        t_request r;
        r.cmd      = CMD_QUERY;
        r.cell_x   = CELL_W'($urandom);
        r.cell_z   = CELL_W'($urandom);
        r.map_byte = BYTE_W'($urandom);
        r.pos_x    = POS_W'(px);
        r.pos_z    = POS_W'(pz);
        send_request(r);
    endtask

    task automatic run_phase(int tx_pct, int rx_pct);
        int sent, pick, ix, iz, k;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        hold_req    = 1'b1;
        sent        = 0;
        while (sent < PHASE_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                // fill some corners of one square, then query inside it
                ix = ($urandom_range(9) == 0) ? (GRID - 2) * $urandom_range(1)
                                              : $urandom_range(GRID - 2);
                iz = ($urandom_range(9) == 0) ? (GRID - 2) * $urandom_range(1)
                                              : $urandom_range(GRID - 2);
                for (k = 0; k < 4; k++) begin
                    if ($urandom_range(3) != 0) begin
                        send_write(ix + k % 2, iz + k / 2, $urandom_range(255));
                        sent++;
                    end
                end
                send_query(ix * ONE + $urandom_range(ONE - 1),
                           iz * ONE + $urandom_range(ONE - 1));
            end else if (pick < 75) begin
                send_write($urandom_range(GRID - 1), $urandom_range(GRID - 1), $urandom_range(255));
            end else if (pick < 92) begin
                send_query($urandom_range(EDGE_LIMIT - 1), $urandom_range(EDGE_LIMIT - 1));
            end else begin
                send_query($urandom, $urandom);
            end
            sent++;
        end
    endtask

    initial begin
        terrain = new();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // corners of the first and the last square, byte extremes and the /10 boundaries
        send_write(0, 0, 255);
        send_write(1, 0, 9);
        send_write(0, 1, 10);
        send_write(1, 1, 99);
        send_write(GRID - 1, GRID - 1, 255);
        send_write(GRID - 2, GRID - 1, 200);
        send_write(GRID - 1, GRID - 2, 130);
        send_write(GRID - 2, GRID - 2, 0);
        send_query(0, 0);
        send_query(8'h80, 8'h40);
        send_query(8'h80, 8'h80);
        send_query(8'hFF, 8'hFF);
        send_query(8'hFF, 0);
        send_query(0, 8'hFF);
        send_query(EDGE_LIMIT - 1, EDGE_LIMIT - 1);
        send_query(EDGE_LIMIT - ONE, EDGE_LIMIT - ONE);
        send_query(EDGE_LIMIT, 0);
        send_query(0, EDGE_LIMIT);
        send_query(-1, 0);
        send_query(0, -1);
        send_query(-32768, -32768);
        send_query(32767, 32767);

        run_phase(36, 70);
        run_phase(70, 36);
        run_phase(0, 0);
        i_s_axis_tvalid <= 1'b0;

        while (terrain.expected_heights.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("covered %0d writes and %0d queries (%0d inside the grid, %0d upper triangle)",
                 terrain.n_writes, terrain.n_queries, terrain.n_hits, terrain.n_upper);
        $display("checked %0d responses, %0d mismatches", terrain.n_checked, terrain.errors);
        if (terrain.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
